>>> rtl/latin_hypercube_sampler_assert.svh
// ---------------------------------------------------------------------------
// Latin hypercube sampler assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef LATIN_HYPERCUBE_SAMPLER_ASSERT_SVH
`define LATIN_HYPERCUBE_SAMPLER_ASSERT_SVH

// Condition must hold at every edge.
`define LHS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define LHS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LHS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/lhs_pkg.sv
// ---------------------------------------------------------------------------
// Latin hypercube sampler package
// Sizes, register indexes, controller states and command/status bundles.
// ---------------------------------------------------------------------------
`default_nettype none

package lhs_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int MAX_DIMS   = 8;

	localparam int SLOT_W = $clog2(MAX_POINTS);       // level / slot index
	localparam int NP_W   = SLOT_W + 1;               // point count
	localparam int DIM_W  = $clog2(MAX_DIMS);
	localparam int ND_W   = DIM_W + 1;
	localparam int RW_W   = 31;                       // random word

	localparam int ROW_ENT    = 32;                   // pool entries per memory row
	localparam int ENT_W      = $clog2(ROW_ENT);
	localparam int ROW_HI_W   = SLOT_W - ENT_W;
	localparam int ROWS       = MAX_DIMS * MAX_POINTS / ROW_ENT;
	localparam int ROW_ADDR_W = DIM_W + ROW_HI_W;

	localparam int DIV_STEPS = RW_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam int IN_DATA_W  = ((RW_W + SLOT_W + 7) / 8) * 8;
	localparam int OUT_FLD_W  = SLOT_W + DIM_W + SLOT_W;
	localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = NP_W;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_GIVEN = 2'd2;

	typedef logic [ROW_ENT-1:0][SLOT_W-1:0] pool_row_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_RD_LAST,
		S_RD_SEL,
		S_WRITE,
		S_OUT
	} lhs_state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic rd_last;
		logic rd_sel;
		logic wr_back;
		logic out_load;
	} lhs_cmd_t;

	typedef struct packed {
		logic first_pick;
		logic div_done;
		logic out_free;
	} lhs_status_t;

	function automatic pool_row_t identity_row(input logic [ROW_HI_W-1:0] hi);
		pool_row_t row;
		for (int j = 0; j < ROW_ENT; j++) begin
			row[j] = {hi, ENT_W'(j)};
		end
		return row;
	endfunction

endpackage

`default_nettype wire

>>> rtl/lhs_ctrl.sv
// ---------------------------------------------------------------------------
// Latin hypercube sampler controller
// Sequences accept, remainder iterations, pool row access and result load.
// ---------------------------------------------------------------------------
`default_nettype none

module lhs_ctrl import lhs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire lhs_status_t status,
	output lhs_cmd_t         cmd
);

	lhs_state_t state_q;
	lhs_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = status.first_pick ? S_RD_LAST : S_DIV;
				end
			end
			S_DIV: begin
				if (status.div_done) begin
					state_nxt = S_RD_LAST;
				end
			end
			S_RD_LAST: state_nxt = S_RD_SEL;
			S_RD_SEL:  state_nxt = S_WRITE;
			S_WRITE:   state_nxt = S_OUT;
			S_OUT: begin
				if (status.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default:   state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_DIV:     cmd.div_step = 1'b1;
			S_RD_LAST: cmd.rd_last  = 1'b1;
			S_RD_SEL:  cmd.rd_sel   = 1'b1;
			S_WRITE:   cmd.wr_back  = 1'b1;
			S_OUT:     cmd.out_load = status.out_free;
			default:   cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/lhs_datapath.sv
// ---------------------------------------------------------------------------
// Latin hypercube sampler datapath
// Registers, counters, restoring remainder unit, level pool memory with
// per-row valid bits, and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "latin_hypercube_sampler_assert.svh"

module lhs_datapath import lhs_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire lhs_cmd_t              cmd,
	output lhs_status_t                status,
	input  wire logic [IN_DATA_W-1:0]  in_data,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [OUT_DATA_W-1:0]      out_data,
	output logic                       out_last,
	output logic                       out_user
);

	logic [NP_W-1:0]   np_q;
	logic [ND_W-1:0]   nd_q;
	logic              first_q;
	logic [SLOT_W-1:0] p_q;
	logic [DIM_W-1:0]  d_q;

	logic [RW_W-1:0]      rw_q;
	logic [SLOT_W-1:0]    sel_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [NP_W-1:0]      remain_q;
	logic [SLOT_W-1:0]    last_q;
	logic                 clamp_q;
	logic [SLOT_W-1:0]    last_val_q;
	logic [SLOT_W-1:0]    coord_q;

	pool_row_t mem [ROWS];
	pool_row_t rdata_q;
	logic      rvalid_q;
	logic [ROWS-1:0] valid_q;

	logic                  out_valid_q;
	logic [SLOT_W-1:0]     out_point_q;
	logic [DIM_W-1:0]      out_dim_q;
	logic [SLOT_W-1:0]     out_coord_q;
	logic                  out_done_q;
	logic                  out_clamp_q;

	logic [RW_W-1:0]       in_rw;
	logic [SLOT_W-1:0]     in_fv;
	logic                  cfg_hit;
	logic [NP_W-1:0]       np_sat;
	logic [ND_W-1:0]       nd_sat;
	logic [NP_W-1:0]       remain_now;
	logic [NP_W-1:0]       np_m1;
	logic                  fv_over;
	logic [NP_W-1:0]       trial;
	logic [NP_W-1:0]       diff;
	logic [SLOT_W-1:0]     rem_nxt;
	logic [ROW_ADDR_W-1:0] row_last;
	logic [ROW_ADDR_W-1:0] row_sel;
	logic [ROW_ADDR_W-1:0] raddr;
	pool_row_t             base_row;
	pool_row_t             wdata;
	logic                  d_wrap;
	logic                  p_wrap;
	logic                  done;

	assign in_rw = in_data[RW_W-1:0];
	assign in_fv = in_data[RW_W+SLOT_W-1:RW_W];

	// configuration registers, stored already saturated
	assign cfg_ready = 1'b1;

	always_comb begin
		cfg_hit = 1'b0;
		case (cfg_index)
			CFG_NUM_POINTS, CFG_NUM_DIMS, CFG_FIRST_GIVEN: cfg_hit = cfg_valid;
			default:                                       cfg_hit = 1'b0;
		endcase
	end

	always_comb begin
		if (cfg_data < NP_W'(2)) begin
			np_sat = NP_W'(2);
		end else if (cfg_data > NP_W'(MAX_POINTS)) begin
			np_sat = NP_W'(MAX_POINTS);
		end else begin
			np_sat = cfg_data;
		end
		if (cfg_data[ND_W-1:0] < ND_W'(1)) begin
			nd_sat = ND_W'(1);
		end else if (cfg_data[ND_W-1:0] > ND_W'(MAX_DIMS)) begin
			nd_sat = ND_W'(MAX_DIMS);
		end else begin
			nd_sat = cfg_data[ND_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			np_q    <= NP_W'(2);
			nd_q    <= ND_W'(2);
			first_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_NUM_POINTS:  np_q    <= np_sat;
				CFG_NUM_DIMS:    nd_q    <= nd_sat;
				CFG_FIRST_GIVEN: first_q <= cfg_data[0];
				default:         ;
			endcase
		end
	end

	// point / dimension counters
	assign d_wrap = ({1'b0, d_q} + ND_W'(1)) >= nd_q;
	assign p_wrap = ({1'b0, p_q} + NP_W'(1)) >= np_q;
	assign done   = d_wrap && p_wrap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= '0;
			d_q <= '0;
		end else if (cfg_hit) begin
			p_q <= '0;
			d_q <= '0;
		end else if (cmd.out_load) begin
			if (d_wrap) begin
				d_q <= '0;
				p_q <= p_wrap ? '0 : p_q + SLOT_W'(1);
			end else begin
				d_q <= d_q + DIM_W'(1);
			end
		end
	end

	// item capture and remainder unit, one quotient bit per cycle
	assign remain_now = np_q - {1'b0, p_q};
	assign np_m1      = np_q - NP_W'(1);
	assign fv_over    = {1'b0, in_fv} >= np_q;
	assign trial      = {sel_q, rw_q[RW_W-1]};
	assign diff       = trial - remain_q;
	assign rem_nxt    = (trial >= remain_q) ? diff[SLOT_W-1:0] : trial[SLOT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rw_q     <= in_rw;
			cnt_q    <= '0;
			remain_q <= remain_now;
			last_q   <= np_m1[SLOT_W-1:0] - p_q;
			if (status.first_pick) begin
				sel_q   <= fv_over ? np_m1[SLOT_W-1:0] : in_fv;
				clamp_q <= fv_over;
			end else begin
				sel_q   <= '0;
				clamp_q <= 1'b0;
			end
		end else if (cmd.div_step) begin
			sel_q <= rem_nxt;
			rw_q  <= {rw_q[RW_W-2:0], 1'b0};
			cnt_q <= cnt_q + DIV_CNT_W'(1);
		end
	end

	assign status.first_pick = first_q && (p_q == '0);
	assign status.div_done   = cnt_q == DIV_CNT_W'(DIV_STEPS - 1);
	assign status.out_free   = !out_valid_q || out_ready;

	// level pools: wide rows, a row not yet written reads as the identity
	assign row_last = {d_q, last_q[SLOT_W-1:ENT_W]};
	assign row_sel  = {d_q, sel_q[SLOT_W-1:ENT_W]};
	assign raddr    = cmd.rd_last ? row_last : row_sel;
	assign base_row = rvalid_q ? rdata_q : identity_row(sel_q[SLOT_W-1:ENT_W]);

	always_comb begin
		wdata                    = base_row;
		wdata[sel_q[ENT_W-1:0]]  = last_val_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_back) begin
			mem[row_sel] <= wdata;
		end
		if (cmd.rd_last || cmd.rd_sel) begin
			rdata_q  <= mem[raddr];
			rvalid_q <= valid_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_sel) begin
			last_val_q <= rvalid_q ? rdata_q[last_q[ENT_W-1:0]] : last_q;
		end
		if (cmd.wr_back) begin
			coord_q <= base_row[sel_q[ENT_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cfg_hit || (cmd.out_load && done)) begin
			valid_q <= '0;
		end else if (cmd.wr_back) begin
			valid_q[row_sel] <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_point_q <= p_q;
			out_dim_q   <= d_q;
			out_coord_q <= coord_q;
			out_done_q  <= done;
			out_clamp_q <= clamp_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {(OUT_DATA_W - OUT_FLD_W)'(0), out_coord_q, out_dim_q, out_point_q};
	assign out_last  = out_done_q;
	assign out_user  = out_clamp_q;

	`LHS_ASSERT_ALWAYS(a_counters_in_range,
		({1'b0, p_q} < np_q) && ({1'b0, d_q} < nd_q), "point or dimension counter out of range")
	`LHS_ASSERT_IMPL(a_slot_below_remaining, cmd.rd_last,
		({1'b0, sel_q} < remain_q) && ({1'b0, last_q} < remain_q), "pool slot beyond remaining levels")
	`LHS_ASSERT_NEXT(a_done_clears_pools, cmd.out_load && done,
		valid_q == '0, "pools not refilled after last coordinate")
	`LHS_ASSERT_NEXT(a_write_marks_row, cmd.wr_back && !cfg_hit,
		valid_q[$past(row_sel)], "written pool row not marked valid")

endmodule

`default_nettype wire

>>> rtl/latin_hypercube_sampler.sv
// ---------------------------------------------------------------------------
// Latin hypercube sampler
// Emits one coordinate of a Latin hypercube design per input transfer,
// drawing levels from per-dimension pools without replacement.
//
//   channel   dir  handshake              payload
//   s_axis    in   tvalid / tready        tdata: random_word, first_value
//   m_axis    out  tvalid / tready        tdata, tlast, tuser
//   cfg       in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item takes a capture, 31 remainder iterations (one bit per
// cycle), three pool memory steps (read last row, read chosen row, write back)
// and a result load. A first-given point 0 skips the remainder unit.
// Reset and every register write refill the pools at once through per-row
// valid bits; no clearing pass.
// A stalled result holds only the result register; the next item is taken
// meanwhile and waits in its final cycle until that register frees.
// ---------------------------------------------------------------------------
`default_nettype none

module latin_hypercube_sampler import lhs_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // random_word, first_value
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // point_index, dim_index, coordinate
	output logic                       m_axis_tlast,   // design_done
	output logic                       m_axis_tuser,   // value_clamped
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	lhs_cmd_t    cmd;
	lhs_status_t status;

	lhs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lhs_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (s_axis_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_user  (m_axis_tuser)
	);

endmodule

`default_nettype wire

>>> test/latin_hypercube_sampler_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Latin hypercube sampler testbench
// Streams random words and given values into the sampler and checks every
// coordinate against a local pool model: point and dimension order, draws
// without replacement, given first point with clamping, saturated sizes and
// design restarts on register writes. Input bursts, output stalls and a long
// output hold-off exercise the handshakes.
// ---------------------------------------------------------------------------

module latin_hypercube_sampler_tb;

	import lhs_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int TARGET_ITEMS = 600;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

	typedef struct packed {
		logic [SLOT_W-1:0] point;
		logic [DIM_W-1:0]  dim;
		logic [SLOT_W-1:0] coord;
		logic              done;
		logic              clamped;
	} coord_t;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // random_word, first_value
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;        // point_index, dim_index, coordinate
	logic                  m_axis_tlast;        // design_done
	logic                  m_axis_tuser;        // value_clamped
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Model state
	logic [SLOT_W-1:0]     level_pool [MAX_DIMS][MAX_POINTS];
	int unsigned           next_point;
	int unsigned           next_dim;
	logic [NP_W-1:0]       points_reg;
	logic [3:0]            dims_reg;
	logic                  given_reg;

	coord_t                expected_coords [$];
	int unsigned           mismatch_count = 0;
	int unsigned           items_sent = 0;
	int unsigned           idle_cycles = 0;
	int unsigned           burst_left = 0;
	bit                    gaps_on = 1'b1;
	int unsigned           hold_left = 0;
	int unsigned           mode_left = 0;
	int unsigned           rx_phase = 0;
	rx_mode_t              rx_mode = RX_OPEN;

	latin_hypercube_sampler u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void refill_pools();
		for (int d = 0; d < MAX_DIMS; d++) begin
			for (int s = 0; s < MAX_POINTS; s++) begin
				level_pool[d][s] = SLOT_W'(s);
			end
		end
	endfunction

	function automatic void restart_design();
		next_point = 0;
		next_dim = 0;
		refill_pools();
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		if (idx == CFG_NUM_POINTS) begin
			points_reg = data;
		end else if (idx == CFG_NUM_DIMS) begin
			dims_reg = data[3:0];
		end else if (idx == CFG_FIRST_GIVEN) begin
			given_reg = data[0];
		end else begin
			return;
		end
		restart_design();
	endfunction

	function automatic int unsigned points_used(input logic [NP_W-1:0] raw);
		int unsigned v;
		v = 32'(raw);
		return (v < 2) ? 2 : ((v > MAX_POINTS) ? MAX_POINTS : v);
	endfunction

	function automatic int unsigned dims_used(input logic [3:0] raw);
		int unsigned v;
		v = 32'(raw);
		return (v < 1) ? 1 : ((v > MAX_DIMS) ? MAX_DIMS : v);
	endfunction

	function automatic coord_t predict_coordinate(input logic [RW_W-1:0] rw,
			input logic [SLOT_W-1:0] fv);
		coord_t      r;
		int unsigned np;
		int unsigned nd;
		int unsigned remaining;
		int unsigned sel;
		np = points_used(points_reg);
		nd = dims_used(dims_reg);
		r = '0;
		if (next_point >= np || next_dim >= nd) begin
			restart_design();
		end
		remaining = np - next_point;
		if (given_reg && next_point == 0) begin
			sel = 32'(fv);
			if (sel >= np) begin
				sel = np - 1;
				r.clamped = 1'b1;
			end
			r.coord = level_pool[next_dim][sel];
			level_pool[next_dim][sel] = level_pool[next_dim][np - 1];
		end else begin
			sel = 32'(rw) % remaining;
			r.coord = level_pool[next_dim][sel];
			level_pool[next_dim][sel] = level_pool[next_dim][remaining - 1];
		end
		r.point = SLOT_W'(next_point);
		r.dim = DIM_W'(next_dim);
		next_dim++;
		if (next_dim >= nd) begin
			next_dim = 0;
			next_point++;
			if (next_point >= np) begin
				next_point = 0;
				r.done = 1'b1;
				refill_pools();
			end
		end
		return r;
	endfunction

	function automatic logic [RW_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return RW_W'($urandom_range(0, 15));
			default: return RW_W'($urandom);
		endcase
	endfunction

	function automatic logic [SLOT_W-1:0] pick_level(input int unsigned np);
		if ($urandom_range(0, 4) < 3) begin
			return SLOT_W'($urandom_range(0, np - 1));
		end
		return SLOT_W'($urandom_range(0, MAX_POINTS - 1));
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatch_count++;
		$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	task automatic stop_sending();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
	endtask

	task automatic drain_results();
		while (expected_coords.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Leave valid high after the transfer; a gap in the next call or a stop lowers it.
	task automatic send_item(input logic [RW_W-1:0] rw, input logic [SLOT_W-1:0] fv);
		int unsigned gap;
		if (cfg_valid) begin
			cfg_valid <= 1'b0;
		end
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on && $urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 12);
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_DATA_W'({fv, rw});
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		expected_coords.push_back(predict_coordinate(rw, fv));
		items_sent++;
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		stop_sending();
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		apply_register(idx, data);
	endtask

	task automatic test_reset_defaults();
		send_item('0, '0);
		send_item('1, '1);
		send_item(RW_W'(1), SLOT_W'($urandom));
		send_item({{(RW_W-1){1'b1}}, 1'b0}, SLOT_W'($urandom));
	endtask

	task automatic test_given_point();
		write_register(CFG_NUM_POINTS, CFG_DATA_W'(5));
		write_register(CFG_NUM_DIMS, CFG_DATA_W'(3));
		write_register(CFG_FIRST_GIVEN, 11'h401);
		// point 0: one past the top, the field maximum, then the lowest level
		send_item(RW_W'($urandom), SLOT_W'(5));
		send_item(RW_W'($urandom), '1);
		send_item(RW_W'($urandom), '0);
		for (int i = 0; i < 12; i++) begin
			send_item((i % 2) ? '1 : RW_W'(i), SLOT_W'($urandom));
		end
	endtask

	task automatic test_saturation();
		write_register(CFG_NUM_POINTS, '0);
		write_register(CFG_NUM_DIMS, 11'h7F0);
		write_register(CFG_FIRST_GIVEN, 11'h7FE);
		for (int i = 0; i < 3; i++) begin
			send_item(pick_word(), SLOT_W'($urandom));
		end
		write_register(CFG_NUM_POINTS, '1);
		write_register(CFG_NUM_DIMS, CFG_DATA_W'(15));
		for (int i = 0; i < 3; i++) begin
			send_item(pick_word(), SLOT_W'($urandom));
		end
		// a write to the spare index must leave the design running
		write_register(CFG_SPARE_INDEX, CFG_DATA_W'($urandom));
		send_item('1, SLOT_W'($urandom));
		send_item('0, SLOT_W'($urandom));
	endtask

	task automatic test_backpressure();
		write_register(CFG_NUM_POINTS, CFG_DATA_W'(6));
		write_register(CFG_NUM_DIMS, CFG_DATA_W'(4));
		write_register(CFG_FIRST_GIVEN, CFG_DATA_W'(1));
		gaps_on = 1'b0;
		hold_left = HOLD_CYCLES;
		for (int i = 0; i < 24; i++) begin
			send_item(pick_word(), pick_level(6));
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_random_designs();
		logic [CFG_DATA_W-1:0] np_raw;
		logic [CFG_DATA_W-1:0] word;
		int unsigned           np_eff;
		int unsigned           len;
		int unsigned           n;
		while (items_sent < TARGET_ITEMS) begin
			if ($urandom_range(0, 3) != 0) begin
				np_raw = CFG_DATA_W'($urandom_range(2, 12));
			end else begin
				case ($urandom_range(0, 5))
					0: np_raw = '0;
					1: np_raw = CFG_DATA_W'(1);
					2: np_raw = CFG_DATA_W'(1023);
					3: np_raw = CFG_DATA_W'(1024);
					4: np_raw = '1;
					default: np_raw = CFG_DATA_W'($urandom_range(13, 2047));
				endcase
			end
			write_register(CFG_NUM_POINTS, np_raw);
			word = CFG_DATA_W'($urandom);
			write_register(CFG_NUM_DIMS, word);
			word = CFG_DATA_W'($urandom);
			write_register(CFG_FIRST_GIVEN, word);
			np_eff = points_used(np_raw);
			len = np_eff * dims_used(dims_reg);
			if (np_eff > 16) begin
				n = $urandom_range(8, 30);
			end else begin
				// whole designs, then a partial one (possibly empty) that the next write abandons
				n = ((len > 40) ? 1 : $urandom_range(1, 3)) * len + $urandom_range(0, len - 1);
			end
			for (int i = 0; i < n; i++) begin
				send_item(pick_word(), pick_level(np_eff));
			end
		end
	endtask

	// Output stall pattern, with an optional long hold-off
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(50, 300);
			end
			mode_left--;
			rx_phase++;
			case (rx_mode)
				RX_OPEN:   m_axis_tready <= 1'b1;
				RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
				RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default:   m_axis_tready <= (rx_phase % 8) < 5;
			endcase
		end
	end

	always @(posedge clk) begin : check_result
		coord_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_coords.size() == 0) begin
				report_mismatch("unexpected result, coordinate",
					32'(m_axis_tdata[2*SLOT_W+DIM_W-1:SLOT_W+DIM_W]), 0);
			end else begin
				want = expected_coords.pop_front();
				if (m_axis_tdata[SLOT_W-1:0] !== want.point)
					report_mismatch("point_index", 32'(m_axis_tdata[SLOT_W-1:0]),
						32'(want.point));
				if (m_axis_tdata[SLOT_W+DIM_W-1:SLOT_W] !== want.dim)
					report_mismatch("dim_index", 32'(m_axis_tdata[SLOT_W+DIM_W-1:SLOT_W]),
						32'(want.dim));
				if (m_axis_tdata[2*SLOT_W+DIM_W-1:SLOT_W+DIM_W] !== want.coord)
					report_mismatch("coordinate",
						32'(m_axis_tdata[2*SLOT_W+DIM_W-1:SLOT_W+DIM_W]), 32'(want.coord));
				if (m_axis_tlast !== want.done)
					report_mismatch("design_done", 32'(m_axis_tlast), 32'(want.done));
				if (m_axis_tuser !== want.clamped)
					report_mismatch("value_clamped", 32'(m_axis_tuser), 32'(want.clamped));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		points_reg = NP_W'(2);
		dims_reg = 4'd2;
		given_reg = 1'b0;
		restart_design();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_given_point();
		test_saturation();
		test_backpressure();
		test_random_designs();
		stop_sending();
		drain_results();
		repeat (40) @(posedge clk);
		if (expected_coords.size() != 0) begin
			report_mismatch("results still outstanding", 0, expected_coords.size());
		end
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
